// File: src/rmq_pkg.sv
// Shared types for the rotation matrix to quaternion block.
`default_nettype none

package rmq_pkg;

    // Component chosen as the pivot, coded as on the pivot_index output
    typedef enum logic [1:0] {
        PIVOT_W = 2'd0,
        PIVOT_X = 2'd1,
        PIVOT_Y = 2'd2,
        PIVOT_Z = 2'd3
    } pivot_t;

endpackage

`default_nettype wire

// File: src/rmq_front.sv
// Front end: diagonal candidates, pivot choice and off-diagonal operand selection.
`default_nettype none

module rmq_front
    import rmq_pkg::*;
#(
    parameter int W  = 16,
    parameter int F  = 14,
    parameter int SB = 19
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [9*W-1:0]      in_mat,
    output logic                     out_valid,
    output logic [SB-1:0]            out_s,
    output logic signed [W:0]        out_d0,
    output logic signed [W:0]        out_d1,
    output logic signed [W:0]        out_d2,
    output pivot_t                   out_idx
);

    localparam int CW = W + 2;

    logic signed [W-1:0] r [9];

    // stage A registers
    logic                 a_valid_reg;
    logic signed [CW-1:0] cand_reg [4];
    logic signed [W:0]    dw_a_reg, dw_b_reg, dw_c_reg;
    logic signed [W:0]    sum_p_reg, sum_q_reg, sum_s_reg;

    // stage B registers
    logic                 b_valid_reg;
    logic [SB-1:0]        s_reg;
    logic signed [W:0]    d0_reg, d1_reg, d2_reg;
    pivot_t               idx_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            r[i] = in_mat[i*W +: W];
        end
    end

    // Stage A: trace, diagonal differences, off-diagonal sums and differences
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
        if (en) begin
            cand_reg[0] <= CW'(r[0]) + CW'(r[4]) + CW'(r[8]);
            cand_reg[1] <= CW'(r[0]) - CW'(r[4]) - CW'(r[8]);
            cand_reg[2] <= CW'(r[4]) - CW'(r[0]) - CW'(r[8]);
            cand_reg[3] <= CW'(r[8]) - CW'(r[0]) - CW'(r[4]);
            dw_a_reg    <= (W+1)'(r[7]) - (W+1)'(r[5]);
            dw_b_reg    <= (W+1)'(r[2]) - (W+1)'(r[6]);
            dw_c_reg    <= (W+1)'(r[3]) - (W+1)'(r[1]);
            sum_p_reg   <= (W+1)'(r[3]) + (W+1)'(r[1]);
            sum_q_reg   <= (W+1)'(r[2]) + (W+1)'(r[6]);
            sum_s_reg   <= (W+1)'(r[7]) + (W+1)'(r[5]);
        end
    end

    // Stage B: largest candidate, earliest wins a tie
    logic                 pick_x, pick_z, pick_hi;
    logic signed [CW-1:0] best_lo, best_hi, best;
    pivot_t               idx_next;
    logic [SB-1:0]        s_next;
    logic signed [W:0]    d0_next, d1_next, d2_next;

    always_comb begin
        pick_x   = cand_reg[1] > cand_reg[0];
        pick_z   = cand_reg[3] > cand_reg[2];
        best_lo  = pick_x ? cand_reg[1] : cand_reg[0];
        best_hi  = pick_z ? cand_reg[3] : cand_reg[2];
        pick_hi  = best_hi > best_lo;
        best     = pick_hi ? best_hi : best_lo;
        if (pick_hi) begin
            idx_next = pick_z ? PIVOT_Z : PIVOT_Y;
        end else begin
            idx_next = pick_x ? PIVOT_X : PIVOT_W;
        end
        // the four candidates sum to zero, so the largest is never negative
        s_next = SB'(unsigned'(best)) + (SB'(1) << F);
        case (idx_next)
            PIVOT_W: begin
                d0_next = dw_a_reg;  d1_next = dw_b_reg;  d2_next = dw_c_reg;
            end
            PIVOT_X: begin
                d0_next = sum_p_reg; d1_next = sum_q_reg; d2_next = dw_a_reg;
            end
            PIVOT_Y: begin
                d0_next = sum_p_reg; d1_next = sum_s_reg; d2_next = dw_b_reg;
            end
            default: begin
                d0_next = sum_q_reg; d1_next = sum_s_reg; d2_next = dw_c_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
        if (en) begin
            s_reg   <= s_next;
            d0_reg  <= d0_next;
            d1_reg  <= d1_next;
            d2_reg  <= d2_next;
            idx_reg <= idx_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_s     = s_reg;
    assign out_d0    = d0_reg;
    assign out_d1    = d1_reg;
    assign out_d2    = d2_reg;
    assign out_idx   = idx_reg;

endmodule

`default_nettype wire

// File: src/rmq_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module rmq_isqrt #(
    parameter int RW     = 17,
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [2*RW-1:0]   in_x,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [RW-1:0]          out_root,
    output logic [SIDE_W-1:0]      out_side
);

    logic [RW-1:0]     valid_reg;
    logic [2*RW-1:0]   x_reg    [RW];
    logic [RW+1:0]     rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [SIDE_W-1:0] side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic              v_in;
        logic [2*RW-1:0]   x_in;
        logic [RW+1:0]     rem_in;
        logic [RW-1:0]     root_in;
        logic [SIDE_W-1:0] side_in;
        logic [RW+3:0]     t, trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign x_in    = in_x;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down two bits, try (4*root + 1)
        always_comb begin
            t     = {rem_in, x_in[2*RW-1 -: 2]};
            trial = {2'b00, root_in, 2'b01};
            ge    = t >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
            if (en) begin
                x_reg[k]    <= x_in << 2;
                rem_reg[k]  <= ge ? (RW+2)'(t - trial) : (RW+2)'(t);
                root_reg[k] <= {root_in[RW-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

`default_nettype wire

// File: src/rmq_div.sv
// Pipelined three-lane restoring divider with a shared divisor, one quotient bit per stage.
`default_nettype none

module rmq_div #(
    parameter int NW     = 32,
    parameter int DW     = 19,
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NW-1:0]     in_num [3],
    input  wire logic [DW-1:0]     in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [NW-1:0]          out_quo [3],
    output logic [SIDE_W-1:0]      out_side
);

    logic [NW-1:0]     valid_reg;
    logic [NW-1:0]     num_reg  [NW][3];
    logic [DW-1:0]     rem_reg  [NW][3];
    logic [NW-1:0]     quo_reg  [NW][3];
    logic [DW-1:0]     den_reg  [NW];
    logic [SIDE_W-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_step
        logic              v_in;
        logic [NW-1:0]     num_in  [3];
        logic [DW-1:0]     rem_in  [3];
        logic [NW-1:0]     quo_in  [3];
        logic [DW-1:0]     den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DW:0]       t       [3];
        logic [2:0]        ge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign den_in  = in_den;
            assign side_in = in_side;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign num_in[l] = in_num[l];
                assign rem_in[l] = '0;
                assign quo_in[l] = '0;
            end
        end else begin : g_next
            assign v_in    = valid_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign num_in[l] = num_reg[k-1][l];
                assign rem_in[l] = rem_reg[k-1][l];
                assign quo_in[l] = quo_reg[k-1][l];
            end
        end

        // shift in the next numerator bit and subtract the divisor if it fits
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                t[l]  = {rem_in[l], num_in[l][NW-1]};
                ge[l] = t[l] >= {1'b0, den_in};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
            if (en) begin
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
                for (int l = 0; l < 3; l++) begin
                    num_reg[k][l] <= num_in[l] << 1;
                    rem_reg[k][l] <= ge[l] ? DW'(t[l] - {1'b0, den_in}) : DW'(t[l]);
                    quo_reg[k][l] <= {quo_in[l][NW-2:0], ge[l]};
                end
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign out_side  = side_reg[NW-1];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            out_quo[l] = quo_reg[NW-1][l];
        end
    end

endmodule

`default_nettype wire

// File: src/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion converter (Shepperd's method), top level.
//
// Input stream: one 3x3 rotation matrix per transfer, nine signed Q.FRAC_BITS
// entries packed row-major in s_axis_tdata. Output stream: one quaternion per
// transfer, x, y, z, w in m_axis_tdata, pivot index and clip flag in
// m_axis_tuser.
// Throughput: one matrix per clock while the receiver does not stall; there is
// no dependence between items. Data passes through the front end, the root
// pipeline (one bit per stage, RB the square-root width), the pivot rounding
// and numerator registers, the divider (one quotient bit per stage, NB the
// quotient width) and the output register. Default format: 16-bit Q1.14.
// Reset (aresetn low, synchronous) clears every valid bit in the pipeline
// and the input skid stage; in-flight data is dropped.
// When the receiver stalls, the whole pipeline holds in place; the input
// skid register takes one more matrix and then s_axis_tready drops until
// the output moves again. Nothing is lost or repeated.
`default_nettype none

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // row0_col0, row0_col1, ... row2_col2 (DATA_WIDTH each), zero padding
    input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w (DATA_WIDTH each), zero padding
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // pivot_index (2 bits), clipped (1 bit)
    output logic [2:0]                                m_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int CW   = W + 2;
    localparam int SB   = ((CW > F + 1) ? CW : F + 1) + 1;
    localparam int XB   = SB + F;
    localparam int RB   = (XB + 1) / 2;
    localparam int DW   = RB + 2;
    localparam int MW   = W + 1;
    localparam int NB   = ((MW + F > RB + 1) ? MW + F : RB + 1) + 1;
    localparam int OW   = ((4*W + 7) / 8) * 8;
    localparam int SQ_SIDE  = 2 + 3*MW;
    localparam int DIV_SIDE = 2 + 3 + RB;

    // pipeline advances whenever the output register is free or being taken
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;

    // Input skid stage
    logic             skid_valid_reg;
    logic [9*W-1:0]   skid_data_reg;
    logic             pipe_in_valid;
    logic [9*W-1:0]   pipe_in_data;

    assign s_axis_tready = !skid_valid_reg;
    assign pipe_in_valid = skid_valid_reg || s_axis_tvalid;
    assign pipe_in_data  = skid_valid_reg ? skid_data_reg : s_axis_tdata[9*W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            skid_valid_reg <= 1'b1;
        end
        if (!en && s_axis_tvalid && s_axis_tready) begin
            skid_data_reg <= s_axis_tdata[9*W-1:0];
        end
    end

    // Front end
    logic              fr_valid;
    logic [SB-1:0]     fr_s;
    logic signed [W:0] fr_d0, fr_d1, fr_d2;
    pivot_t            fr_idx;

    rmq_front #(.W(W), .F(F), .SB(SB)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pipe_in_valid),
        .in_mat    (pipe_in_data),
        .out_valid (fr_valid),
        .out_s     (fr_s),
        .out_d0    (fr_d0),
        .out_d1    (fr_d1),
        .out_d2    (fr_d2),
        .out_idx   (fr_idx)
    );

    // Square root of S * 2^F
    logic [2*RB-1:0]    sq_x;
    logic               sq_valid;
    logic [RB-1:0]      sq_root;
    logic [SQ_SIDE-1:0] sq_side;

    assign sq_x = (2*RB)'(fr_s) << F;

    rmq_isqrt #(.RW(RB), .SIDE_W(SQ_SIDE)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_x      (sq_x),
        .in_side   ({fr_idx, fr_d2, fr_d1, fr_d0}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Pivot rounding and operand magnitudes
    logic [RB:0]       root_inc;
    logic signed [W:0] sq_d [3];
    logic              p_valid_reg;
    logic [RB-1:0]     p_v_reg;
    logic [MW-1:0]     p_mag_reg [3];
    logic [2:0]        p_neg_reg;
    logic [1:0]        p_idx_reg;

    assign root_inc = {1'b0, sq_root} + (RB+1)'(1);
    assign sq_d[0]  = sq_side[MW-1:0];
    assign sq_d[1]  = sq_side[2*MW-1:MW];
    assign sq_d[2]  = sq_side[3*MW-1:2*MW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= sq_valid;
        end
        if (en) begin
            p_v_reg   <= root_inc[RB:1];
            p_idx_reg <= sq_side[SQ_SIDE-1 -: 2];
            for (int l = 0; l < 3; l++) begin
                p_neg_reg[l] <= sq_d[l][W];
                p_mag_reg[l] <= sq_d[l][W] ? MW'(-sq_d[l]) : MW'(sq_d[l]);
            end
        end
    end

    // Numerators (|D| << F) + 2V and divisor 4V
    logic                n_valid_reg;
    logic [NB-1:0]       n_num_reg [3];
    logic [DW-1:0]       n_den_reg;
    logic [DIV_SIDE-1:0] n_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (en) begin
            n_valid_reg <= p_valid_reg;
        end
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                n_num_reg[l] <= (NB'(p_mag_reg[l]) << F) + (NB'(p_v_reg) << 1);
            end
            n_den_reg  <= DW'(p_v_reg) << 2;
            n_side_reg <= {p_idx_reg, p_neg_reg, p_v_reg};
        end
    end

    // Divider
    logic                dv_valid;
    logic [NB-1:0]       dv_quo [3];
    logic [DIV_SIDE-1:0] dv_side;

    rmq_div #(.NW(NB), .DW(DW), .SIDE_W(DIV_SIDE)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n_valid_reg),
        .in_num    (n_num_reg),
        .in_den    (n_den_reg),
        .in_side   (n_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // Sign, saturation and component placement
    logic signed [NB:0]  hi_c, lo_c;
    logic signed [NB:0]  val [4];
    logic signed [W-1:0] sat [4];
    logic [3:0]          clip_bits;
    logic [2:0]          dv_neg;
    logic [RB-1:0]       dv_v;
    pivot_t              dv_idx;
    logic signed [W-1:0] qx_next, qy_next, qz_next, qw_next;

    assign hi_c   = {{(NB+2-W){1'b0}}, {(W-1){1'b1}}};
    assign lo_c   = {{(NB+2-W){1'b1}}, {(W-1){1'b0}}};
    assign dv_v   = dv_side[RB-1:0];
    assign dv_neg = dv_side[RB+2:RB];
    assign dv_idx = pivot_t'(dv_side[DIV_SIDE-1 -: 2]);

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            val[l] = dv_neg[l] ? -signed'({1'b0, dv_quo[l]}) : signed'({1'b0, dv_quo[l]});
        end
        val[3] = signed'({1'b0, NB'(dv_v)});
        for (int l = 0; l < 4; l++) begin
            if (val[l] > hi_c) begin
                sat[l]       = hi_c[W-1:0];
                clip_bits[l] = 1'b1;
            end else if (val[l] < lo_c) begin
                sat[l]       = lo_c[W-1:0];
                clip_bits[l] = 1'b1;
            end else begin
                sat[l]       = val[l][W-1:0];
                clip_bits[l] = 1'b0;
            end
        end
        case (dv_idx)
            PIVOT_W: begin
                qx_next = sat[0]; qy_next = sat[1]; qz_next = sat[2]; qw_next = sat[3];
            end
            PIVOT_X: begin
                qx_next = sat[3]; qy_next = sat[0]; qz_next = sat[1]; qw_next = sat[2];
            end
            PIVOT_Y: begin
                qx_next = sat[0]; qy_next = sat[3]; qz_next = sat[1]; qw_next = sat[2];
            end
            default: begin
                qx_next = sat[0]; qy_next = sat[1]; qz_next = sat[3]; qw_next = sat[2];
            end
        endcase
    end

    // Output register
    logic                o_valid_reg;
    logic signed [W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    pivot_t              o_idx_reg;
    logic                o_clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= dv_valid;
        end
        if (en) begin
            qx_reg     <= qx_next;
            qy_reg     <= qy_next;
            qz_reg     <= qz_next;
            qw_reg     <= qw_next;
            o_idx_reg  <= dv_idx;
            o_clip_reg <= |clip_bits;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = OW'({qw_reg, qz_reg, qy_reg, qx_reg});
    assign m_axis_tuser  = {o_clip_reg, o_idx_reg};

endmodule

`default_nettype wire

// File: bench/tb_rotation_matrix_to_quaternion.sv
// Testbench for the rotation matrix to quaternion converter: random and directed streams.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int IN_W = ((9*DW+7)/8)*8;
    localparam int OUT_W = ((4*DW+7)/8)*8;
    localparam int LATENCY = 54;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [DW-1:0] qx, qy, qz, qw;
        pivot_t pivot;
        logic clip;
    } quat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;

    rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic [IN_W-1:0] pending_mats[$];
    quat_t expected_quats[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int clip_count = 0;
    int pivot_hits[4] = '{0, 0, 0, 0};
    bit feeding_done = 0;
    bit hold_sender = 0;
    bit long_hold_req = 0;
    longint cycles = 0;

    // integer square root, floor
    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    // D * 2^FB / (4V), rounded half away from zero
    function automatic longint quot_round(longint d, longint v);
        longint mag, q;
        if (v == 0) return 0;
        mag = (d < 0) ? -d : d;
        q = ((mag << FB) + 2*v) / (4*v);
        return (d < 0) ? -q : q;
    endfunction

    function automatic logic [DW-1:0] sat(longint v, ref logic clip);
        longint hi, lo;
        hi = (64'sd1 <<< (DW-1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin v = hi; clip = 1'b1; end
        if (v < lo) begin v = lo; clip = 1'b1; end
        return v[DW-1:0];
    endfunction

    function automatic quat_t predict_quat(logic [IN_W-1:0] mat);
        longint r[3][3];
        longint cand[4];
        longint best, piv, d0, d1, d2;
        longint c[4];
        int idx;
        logic clip;
        quat_t q;
        for (int i = 0; i < 9; i++) r[i/3][i%3] = longint'($signed(mat[i*DW +: DW]));
        cand[0] = r[0][0] + r[1][1] + r[2][2];
        cand[1] = r[0][0] - r[1][1] - r[2][2];
        cand[2] = r[1][1] - r[0][0] - r[2][2];
        cand[3] = r[2][2] - r[0][0] - r[1][1];
        best = cand[0];
        idx = 0;
        for (int i = 1; i < 4; i++) if (cand[i] > best) begin best = cand[i]; idx = i; end
        best += longint'(1) << FB;
        if (best < 0) best = 0;
        piv = longint'((isqrt(longint'(best) << FB) + 1) >> 1);
        case (idx)
            0: begin
                d0 = r[2][1]-r[1][2]; d1 = r[0][2]-r[2][0]; d2 = r[1][0]-r[0][1];
                c = '{quot_round(d0,piv), quot_round(d1,piv), quot_round(d2,piv), piv};
            end
            1: begin
                d0 = r[1][0]+r[0][1]; d1 = r[0][2]+r[2][0]; d2 = r[2][1]-r[1][2];
                c = '{piv, quot_round(d0,piv), quot_round(d1,piv), quot_round(d2,piv)};
            end
            2: begin
                d0 = r[1][0]+r[0][1]; d1 = r[2][1]+r[1][2]; d2 = r[0][2]-r[2][0];
                c = '{quot_round(d0,piv), piv, quot_round(d1,piv), quot_round(d2,piv)};
            end
            default: begin
                d0 = r[0][2]+r[2][0]; d1 = r[2][1]+r[1][2]; d2 = r[1][0]-r[0][1];
                c = '{quot_round(d0,piv), quot_round(d1,piv), piv, quot_round(d2,piv)};
            end
        endcase
        clip = 1'b0;
        q.qx = sat(c[0], clip);
        q.qy = sat(c[1], clip);
        q.qz = sat(c[2], clip);
        q.qw = sat(c[3], clip);
        q.pivot = pivot_t'(idx[1:0]);
        q.clip = clip;
        return q;
    endfunction

    function automatic logic [IN_W-1:0] pack_mat(int e[9]);
        logic [IN_W-1:0] m;
        m = '0;
        for (int i = 0; i < 9; i++) m[i*DW +: DW] = e[i][DW-1:0];
        return m;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // random entry: mostly near-rotation range, sometimes full range or extremes
    function automatic int rand_entry(int mode);
        case (mode)
            0: return $urandom_range(0, 32768) - 16384;
            1: return $urandom_range(0, 65535) - 32768;
            default: return ($urandom_range(0, 1) == 1) ? 32767 : -32768;
        endcase
    endfunction

    // random proper rotation about a principal axis, small noise on some entries
    function automatic logic [IN_W-1:0] rand_rotation();
        int e[9];
        int c, s, ax;
        real ang;
        ang = ($urandom_range(0, 62831) / 10000.0);
        c = $rtoi($cos(ang) * 16384.0);
        s = $rtoi($sin(ang) * 16384.0);
        ax = $urandom_range(0, 2);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        case (ax)
            0: e = '{16384, 0, 0, 0, c, -s, 0, s, c};
            1: e = '{c, 0, s, 0, 16384, 0, -s, 0, c};
            default: e = '{c, -s, 0, s, c, 0, 0, 0, 16384};
        endcase
        for (int i = 0; i < 9; i++) begin
            if ($urandom_range(0, 3) == 0) e[i] += $urandom_range(0, 200) - 100;
            if (e[i] > 32767) e[i] = 32767;
        end
        return pack_mat(e);
    endfunction

    // stimulus
    initial begin
        int e[9];
        int mode;
        int dirs[][9];
        dirs = '{
            '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384},
            '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384},
            '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384},
            '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384},
            '{0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
            '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
            '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768},
            '{0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0},
            '{-32768, 32767, 32767, 32767, -32768, -32768, -32768, 32767, 32767},
            '{8192, 0, 0, 0, 8192, 0, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 0, 0, 8192},
            '{0, 0, 0, 0, 8192, 0, 0, 0, 0},
            '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384},
            '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384},
            '{16384, 32767, -32768, -32768, 16384, 32767, 32767, -32768, -16384},
            '{-32768, 0, 0, 0, 32767, 0, 0, 0, -32768}
        };
        foreach (dirs[i]) pending_mats.push_back(pack_mat(dirs[i]));
        while (pending_mats.size() < 1500) begin
            mode = $urandom_range(0, 99);
            if (mode < 45) pending_mats.push_back(rand_rotation());
            else begin
                for (int i = 0; i < 9; i++)
                    e[i] = rand_entry(mode < 80 ? 0 : (mode < 97 ? 1 : 2));
                pending_mats.push_back(pack_mat(e));
            end
        end
        feeding_done = 1;
    end

    // reset, a sender pause at 400 matrices until every result has drained, and the long receiver hold request
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (sent >= 400);
        @(posedge aclk);
        hold_sender <= 1'b1;
        wait (expected_quats.size() == 0 && sent == received);
        @(posedge aclk);
        hold_sender <= 1'b0;
        wait (sent >= 800);
        long_hold_req <= 1'b1;
    end

    // driver
    int drv_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_quats.push_back(predict_quat(s_axis_tdata));
                sent <= sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (!hold_sender && pending_mats.size() > 0) begin
                    s_axis_tdata <= pending_mats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    drv_gap <= gap_len();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall control, with one long hold-off
    int rcv_gap = 0;
    bit long_done = 0;
    always @(posedge aclk) begin
        if (long_hold_req && !long_done) begin
            long_done <= 1'b1;
            rcv_gap <= 300;
            m_axis_tready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0) rcv_gap <= gap_len();
        end
    end

    // monitor
    always @(posedge aclk) begin
        quat_t got, want;
        cycles <= cycles + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.qx = m_axis_tdata[0 +: DW];
            got.qy = m_axis_tdata[DW +: DW];
            got.qz = m_axis_tdata[2*DW +: DW];
            got.qw = m_axis_tdata[3*DW +: DW];
            got.pivot = pivot_t'(m_axis_tuser[1:0]);
            got.clip = m_axis_tuser[2];
            received <= received + 1;
            if (expected_quats.size() == 0) begin
                $display("%0t: unexpected transfer, actual %p", $time, got);
                errors <= errors + 1;
            end else begin
                want = expected_quats.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    errors <= errors + 1;
                end
                pivot_hits[want.pivot] <= pivot_hits[want.pivot] + 1;
                if (want.clip) clip_count <= clip_count + 1;
            end
        end
    end

    // end of run
    initial begin
        wait (feeding_done && pending_mats.size() == 0 && !s_axis_tvalid
              && expected_quats.size() == 0 && sent == received && sent > 0);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Converted %0d matrices; pivots w/x/y/z %0d/%0d/%0d/%0d, clipped %0d.",
                 received, pivot_hits[0], pivot_hits[1], pivot_hits[2], pivot_hits[3],
                 clip_count);
        if (errors == 0 && expected_quats.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: rotation_matrix_to_quaternion.f
src/rmq_pkg.sv
src/rmq_front.sv
src/rmq_isqrt.sv
src/rmq_div.sv
src/rotation_matrix_to_quaternion.sv
bench/tb_rotation_matrix_to_quaternion.sv
